/* src/bvm_pkg.sv */
// bvm_pkg: payload types, register indexes, charge thresholds and the
// li-ion percentage table for the battery voltage monitor.
// no dependencies.
`default_nettype none

package bvm_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_DIVIDER_RATIO = 8'd0;
    localparam logic [7:0] CFG_EMA_ALPHA     = 8'd1;

    localparam logic [15:0] DIVIDER_RESET = 16'd8192;
    localparam logic [15:0] ALPHA_RESET   = 16'd6554;

    // item kinds
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_PROCESS = 1'b1;

    // charge thresholds in q.8 millivolts
    localparam logic [23:0] LVL_CHARGE_HIGH = 24'd1088000; // 4250 mV
    localparam logic [23:0] LVL_HOLD_HIGH   = 24'd1075200; // 4200 mV
    localparam logic [23:0] LVL_FULL        = 24'd1062400; // 4150 mV
    localparam logic signed [24:0] DELTA_RISE = 25'sd38400;  // 150 mV
    localparam logic signed [24:0] DELTA_FALL = -25'sd25600; // 100 mV

    localparam logic [6:0] PCT_FULL = 7'd100;

    // stepped li-ion table, highest voltage first
    localparam int PCT_STEPS = 11;
    localparam logic [15:0] PCT_MV [PCT_STEPS] = '{
        16'd4200, 16'd4060, 16'd3980, 16'd3920, 16'd3870, 16'd3820,
        16'd3790, 16'd3770, 16'd3740, 16'd3680, 16'd3450
    };
    localparam logic [6:0] PCT_VAL [PCT_STEPS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd5
    };

    typedef struct packed {
        logic        req_type;
        logic [11:0] sample_mv;
    } in_item_t;

    typedef struct packed {
        logic [15:0] voltage_mv;
        logic [6:0]  percent;
        logic        is_charging;
        logic        valid_res;
    } out_item_t;

    // operands of the shared multiplier: a is unsigned, b is two's complement
    typedef struct packed {
        logic [15:0] a;
        logic [24:0] b;
    } mul_req_t;

    // first table step the level reaches, compared in whole millivolts
    function automatic logic [6:0] level_percent(input logic [15:0] lvl_mv);
        logic [6:0] pct;
        pct = 7'd0;
        for (int k = PCT_STEPS - 1; k >= 0; k--) begin
            if (lvl_mv >= PCT_MV[k]) begin
                pct = PCT_VAL[k];
            end
        end
        return pct;
    endfunction

endpackage

`default_nettype wire

/* src/battery_voltage_median_ema_monitor_unit.sv */
// battery_voltage_median_ema_monitor_unit: sample ring, serial median search,
// scaling and ema through one shared multiplier, charger detection.
// depends on bvm_pkg and bvm_mul.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  input    | s_valid / s_ready  | s_data  (in_item_t)
//  result   | m_valid / m_ready  | m_data  (out_item_t)
//  config   | cfg_valid/cfg_ready| cfg_index (8 b), cfg_data (16 b)
//
// sample items and early process items go straight to the result; a process
// item on a full ring tests ring entries in index order against the whole ring
// until one holds the median; the seeding item skips the ema and charger steps.
// aresetn is synchronous; the ring itself is not cleared.
// s_ready is high only when idle; a held result stalls the sequencer at
// its last step until the output register frees up.
`default_nettype none

module battery_voltage_median_ema_monitor_unit
    import bvm_pkg::*;
#(
    parameter int RING_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] MED_RANK = CNT_W'(RING_DEPTH / 2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CAND  = 4'd1;
    localparam logic [3:0] S_CWAIT = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_EMA   = 4'd7;
    localparam logic [3:0] S_CHG   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [15:0]      divider_reg;
    logic [15:0]      alpha_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic             ring_full_reg;
    logic             seeded_reg;
    logic [23:0]      filt_reg;
    logic [23:0]      prior_reg;
    logic             charge_reg;
    logic [IDX_W-1:0] cand_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [CNT_W-1:0] lt_cnt_reg;
    logic [CNT_W-1:0] le_cnt_reg;
    logic [11:0]      cand_reg;
    logic [11:0]      median_reg;
    logic [23:0]      cur_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic [11:0]      ring_mem [RING_DEPTH];
    logic [11:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic             s_fire;
    logic             out_load;
    logic             lt_inc, le_inc;
    logic [CNT_W-1:0] lt_sum, le_sum;
    logic             found;
    mul_req_t         mul_req;
    logic signed [41:0] prod_reg;
    logic [24:0]      ema_sum;
    logic signed [24:0] delta;
    logic [6:0]       pct;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg <= DIVIDER_RESET;
            alpha_reg   <= ALPHA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIVIDER_RATIO: divider_reg <= cfg_data;
                CFG_EMA_ALPHA:     alpha_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ring read address follows the median search
    always_comb begin
        unique case (state_reg)
            S_CAND:  rd_addr = cand_idx_reg;
            S_CMP:   rd_addr = (cmp_idx_reg == LAST_IDX) ? '0 : cmp_idx_reg + 1'b1;
            default: rd_addr = '0;
        endcase
    end

    // sample ring: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.req_type == REQ_SAMPLE)) begin
            ring_mem[ptr_reg] <= s_data.sample_mv;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // rank counts of the candidate against the entry read this cycle
    assign lt_inc = (rd_data_reg < cand_reg);
    assign le_inc = (rd_data_reg <= cand_reg);
    assign lt_sum = lt_cnt_reg + CNT_W'(lt_inc);
    assign le_sum = le_cnt_reg + CNT_W'(le_inc);
    assign found  = (lt_sum <= MED_RANK) && (le_sum > MED_RANK);

    // shared multiplier operands
    always_comb begin
        if (state_reg == S_MUL2) begin
            mul_req.a = alpha_reg;
            mul_req.b = {1'b0, cur_reg} - {1'b0, filt_reg};
        end else begin
            mul_req.a = divider_reg;
            mul_req.b = {13'd0, median_reg};
        end
    end

    bvm_mul u_mul (
        .aclk     (aclk),
        .req      (mul_req),
        .prod_reg (prod_reg)
    );

    // ema as filt + alpha*(cur - filt) >> 16, floor on the signed product
    assign ema_sum = {1'b0, filt_reg} + prod_reg[40:16];
    assign delta   = $signed({1'b0, filt_reg}) - $signed({1'b0, prior_reg});

    // result percentage
    always_comb begin
        if (charge_reg && (filt_reg >= LVL_FULL)) begin
            pct = PCT_FULL;
        end else begin
            pct = level_percent(filt_reg[23:8]);
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if ((s_data.req_type == REQ_PROCESS) && ring_full_reg) begin
                        state_next = S_CAND;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CAND:  state_next = S_CWAIT;
            S_CWAIT: state_next = S_CMP;
            S_CMP: begin
                if (cmp_idx_reg == LAST_IDX) begin
                    state_next = found ? S_MUL1 : S_CAND;
                end
            end
            S_MUL1:  state_next = S_SCALE;
            S_SCALE: state_next = seeded_reg ? S_MUL2 : S_OUT;
            S_MUL2:  state_next = S_EMA;
            S_EMA:   state_next = S_CHG;
            S_CHG:   state_next = S_OUT;
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            ring_full_reg <= 1'b0;
            seeded_reg    <= 1'b0;
            filt_reg      <= '0;
            prior_reg     <= '0;
            charge_reg    <= 1'b0;
            cand_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            lt_cnt_reg    <= '0;
            le_cnt_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            // ring pointer on sample transactions
            if (s_fire && (s_data.req_type == REQ_SAMPLE)) begin
                if (ptr_reg == LAST_IDX) begin
                    ptr_reg       <= '0;
                    ring_full_reg <= 1'b1;
                end else begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end

            // median search counters
            if (s_fire) begin
                cand_idx_reg <= '0;
            end
            if (state_reg == S_CWAIT) begin
                cmp_idx_reg <= '0;
                lt_cnt_reg  <= '0;
                le_cnt_reg  <= '0;
            end
            if (state_reg == S_CMP) begin
                cmp_idx_reg <= cmp_idx_reg + 1'b1;
                lt_cnt_reg  <= lt_sum;
                le_cnt_reg  <= le_sum;
                if ((cmp_idx_reg == LAST_IDX) && !found) begin
                    cand_idx_reg <= cand_idx_reg + 1'b1;
                end
            end

            // first process seeds both levels
            if ((state_reg == S_SCALE) && !seeded_reg) begin
                filt_reg   <= prod_reg[27:4];
                prior_reg  <= prod_reg[27:4];
                seeded_reg <= 1'b1;
            end
            if (state_reg == S_EMA) begin
                filt_reg <= ema_sum[23:0];
            end

            // charger hysteresis
            if (state_reg == S_CHG) begin
                if ((filt_reg > LVL_CHARGE_HIGH) || (delta > DELTA_RISE)) begin
                    charge_reg <= 1'b1;
                end else if ((delta < DELTA_FALL) || (filt_reg < LVL_FULL)) begin
                    if (filt_reg < LVL_HOLD_HIGH) begin
                        charge_reg <= 1'b0;
                    end
                end
                prior_reg <= filt_reg;
            end

            // output register
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // search and scaling payload
    always_ff @(posedge aclk) begin
        if (state_reg == S_CWAIT) begin
            cand_reg <= rd_data_reg;
        end
        if ((state_reg == S_CMP) && (cmp_idx_reg == LAST_IDX) && found) begin
            median_reg <= cand_reg;
        end
        if (state_reg == S_SCALE) begin
            cur_reg <= prod_reg[27:4];
        end
        if (out_load) begin
            m_data_reg.voltage_mv  <= filt_reg[23:8];
            m_data_reg.percent     <= pct;
            m_data_reg.is_charging <= charge_reg;
            m_data_reg.valid_res   <= seeded_reg;
        end
    end

    // a full ring stays full until reset
    a_ring_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_full_reg |=> ring_full_reg)
        else $error("ring full flag dropped");

    // the ema stays seeded once it has been seeded
    a_seeded_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    // rank counts are ordered during the search
    a_rank_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (le_cnt_reg >= lt_cnt_reg))
        else $error("rank counts out of order");

    // a process transaction on a full ring starts the median search
    a_search_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_data.req_type == REQ_PROCESS) && ring_full_reg)
        |=> (state_reg == S_CAND) && !s_ready)
        else $error("median search did not start");

endmodule

`default_nettype wire

/* src/bvm_mul.sv */
// bvm_mul: shared 17x25 signed multiplier with a registered product.
// depends on bvm_pkg for the operand struct.
`default_nettype none

module bvm_mul
    import bvm_pkg::*;
(
    input  wire logic                aclk,
    input  wire mul_req_t            req,
    output logic signed [41:0]       prod_reg
);

    logic signed [41:0] prod_next;

    // unsigned a gets a zero sign bit
    assign prod_next = $signed({1'b0, req.a}) * $signed(req.b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire
